// File: rtl/binary_3x3_lut_image_filter_core_macros.svh
// Assertion macros shared by the filter RTL.
// Included by each module that carries concurrent checks; no other dependencies.
`ifndef BINARY_3X3_LUT_IMAGE_FILTER_CORE_MACROS_SVH
`define BINARY_3X3_LUT_IMAGE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("filter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BLF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("filter check failed");

`endif

// File: rtl/blf_pkg.sv
// Shared types, codes and helpers for the binary 3x3 lookup-table filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package blf_pkg;

    localparam int CFG_W = 9;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND   = 2'd2;

    // item modes
    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam int          LIT_W   = 17;
    localparam logic [16:0] LIT_MAX = 17'h1FFFF;

    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic             pixel_out;
        logic [7:0]       out_row;
        logic [7:0]       out_col;
        logic             frame_last;
        logic [LIT_W-1:0] lit_count;
    } t_result;

    // top-left neighbour lands in bit 8, bottom-right in bit 0
    function automatic logic [8:0] lut_index(input logic [2:0] l, input logic [2:0] m,
                                             input logic [2:0] r);
        return {l[2], m[2], r[2], l[1], m[1], r[1], l[0], m[0], r[0]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/blf_linebuf.sv
// Two one-bit line buffers held side by side in one synchronous memory.
// Registered read with same-address write forwarding; uses blf_pkg.
`default_nettype none

module blf_linebuf #(
    parameter int MAX_WIDTH = 256,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [1:0]    i_wr_data,
    output      logic [1:0]    o_rd_data
);
    import blf_pkg::*;

    // bit 1: upper line, bit 0: lower line
    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_q;
    logic       r_fwd;
    logic [1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            // the write in this same edge is newer than the array contents
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

`default_nettype wire

// File: rtl/blf_table.sv
// Lookup table memory: eight 64-bit words, one write port, two registered reads.
// Uses blf_pkg.
`default_nettype none

module blf_table (
    input  wire logic        i_clk,
    input  wire logic        i_wr_en,
    input  wire logic [2:0]  i_wr_addr,
    input  wire logic [63:0] i_wr_data,
    input  wire logic [2:0]  i_rd_addr_a,
    input  wire logic [2:0]  i_rd_addr_b,
    output      logic [63:0] o_rd_data_a,
    output      logic [63:0] o_rd_data_b
);
    import blf_pkg::*;

    logic [63:0] r_mem [8];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// File: rtl/blf_outq.sv
// Result queue: up to two pushes per cycle, one pop, stall-based output.
// Uses blf_pkg and the assertion macro header.
`default_nettype none
`include "binary_3x3_lut_image_filter_core_macros.svh"

module blf_outq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push_a,
    input  wire blf_pkg::t_result       i_res_a,
    input  wire logic                   i_push_b,
    input  wire blf_pkg::t_result       i_res_b,
    input  wire logic                   i_stall,
    output      logic                   o_valid,
    output      blf_pkg::t_result       o_res,
    output      logic [blf_pkg::OQ_CW-1:0] o_count
);
    import blf_pkg::*;

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp;
    logic [OQ_AW-1:0] r_rp;
    logic [OQ_CW-1:0] r_count;
    logic [OQ_CW-1:0] n_count;
    logic [OQ_AW-1:0] wp_b;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;
    assign wp_b    = i_push_a ? r_wp + OQ_AW'(1) : r_wp;

    always_comb begin
        n_count = r_count + OQ_CW'(i_push_a) + OQ_CW'(i_push_b) - OQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wp] <= i_res_a;
        end
        if (i_push_b) begin
            r_mem[wp_b] <= i_res_b;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + OQ_AW'(i_push_a) + OQ_AW'(i_push_b);
            r_rp    <= r_rp + OQ_AW'(pop);
            r_count <= n_count;
        end
    end

    `BLF_ASSERT_IMPL(a_oq_no_overflow, i_clk, i_rst_n, 1'b1, r_count <= OQ_CW'(OQ_DEPTH))
    `BLF_ASSERT_NEXT(a_oq_pop_only, i_clk, i_rst_n, pop && !i_push_a && !i_push_b, r_count == $past(r_count) - OQ_CW'(1))

endmodule

`default_nettype wire

// File: rtl/binary_3x3_lut_image_filter_core.sv
// Streaming binary 3x3 lookup-table filter, top level: control, window and counters.
// Instantiates blf_linebuf, blf_table and blf_outq; uses blf_pkg and the macro header.
//
// Usage: items enter on the input channel (valid/stall) in raster order. Mode 0 writes
// a 64-bit slice of the 512-entry table, mode 1 is an image pixel, mode 2 a flush item;
// a row of flush items after the frame pushes out the last row. Results leave on the
// output channel (valid/stall), one per filtered pixel, the final one marked frame_last
// and carrying the frame's running lit count.
// Throughput: one item per clock unless the input stalls. Each item reads the line-buffer
// memory once and the table memory twice; both reads are registered, so an item runs
// through three stages (control, window and table read, bit select) with forwarding on
// the line buffer. Output pixel (r,c) is produced from accepted pixel (r+1,c+1), or
// from the last pixel of row r+1 for the rightmost column.
// When the receiver stalls, results collect in an eight-entry queue; the input stalls
// once the queue cannot take the worst case from items still in flight.
// Reset clears counters, window and queue and sets width 256, height 256, background 0.
// Table and line buffers are not cleared: load the table before sending pixels.
// Configuration writes are always ready and must only be made while the block is idle.
`default_nettype none
`include "binary_3x3_lut_image_filter_core_macros.svh"

module binary_3x3_lut_image_filter_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic        i_pixel_in,
    input  wire logic [2:0]  i_table_word_index,
    input  wire logic [63:0] i_table_word,
    // results
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic        o_pixel_out,
    output      logic [7:0]  o_out_row,
    output      logic [7:0]  o_out_col,
    output      logic        o_frame_last,
    output      logic [16:0] o_lit_count,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);
    import blf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = (WW > CFG_W) ? WW : CFG_W;
    localparam int LH = (RW > CFG_W) ? RW : CFG_W;

    // configuration
    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             r_background;

    // stream position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // control stage
    logic [LW-1:0] w_eff;
    logic [LH-1:0] h_eff;
    logic          in_acc;
    logic          flushing;
    logic          proc;
    logic          last_col;

    // window stage
    logic          r_s1_valid;
    logic          r_s1_proc;
    logic          r_s1_tload;
    logic [2:0]    r_s1_tidx;
    logic [63:0]   r_s1_tword;
    logic [CW-1:0] r_s1_c;
    logic          r_s1_bot;
    logic          r_s1_top_bg;
    logic          r_s1_mid_bg;
    logic          r_s1_first;
    logic          r_s1_emit1;
    logic          r_s1_emit2;
    logic          r_s1_last;
    logic          r_s1_clear;
    logic [7:0]    r_s1_row;
    logic [5:0]    r_win;
    logic [5:0]    n_win;
    logic [1:0]    lb_rdata;
    logic [2:0]    bgcol;
    logic          s1_top;
    logic          s1_mid;
    logic [2:0]    s1_new;
    logic [8:0]    idx1;
    logic [8:0]    idx2;
    logic          s1_work;

    // bit-select stage
    logic          r_s2_valid;
    logic          r_s2_emit1;
    logic          r_s2_emit2;
    logic          r_s2_last;
    logic          r_s2_clear;
    logic [5:0]    r_s2_off1;
    logic [5:0]    r_s2_off2;
    logic [7:0]    r_s2_row;
    logic [CW-1:0] r_s2_c;
    logic [63:0]   tq_a;
    logic [63:0]   tq_b;
    logic [LIT_W-1:0] r_lit;
    logic [LIT_W-1:0] lit_a;
    logic [LIT_W-1:0] lit_b;
    logic          bit_a;
    logic          bit_b;
    logic          push_a;
    logic          push_b;
    t_result       res_a;
    t_result       res_b;
    t_result       q_res;
    logic [OQ_CW-1:0] q_count;
    logic [OQ_CW+1:0] q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= CFG_W'(256);
            r_frame_height <= CFG_W'(256);
            r_background   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_BACKGROUND:   r_background   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- control stage ----------------
    always_comb begin
        if (r_line_width == '0) begin
            w_eff = LW'(1);
        end else if (LW'(r_line_width) > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = LW'(r_line_width);
        end
        if (r_frame_height == '0) begin
            h_eff = LH'(1);
        end else if (LH'(r_frame_height) > LH'(MAX_HEIGHT)) begin
            h_eff = LH'(MAX_HEIGHT);
        end else begin
            h_eff = LH'(r_frame_height);
        end
    end

    // leave room in the queue for two results from every item in flight
    assign q_head = (OQ_CW+2)'(q_count) + (OQ_CW+2)'({r_s1_valid, 1'b0})
                  + (OQ_CW+2)'({r_s2_valid, 1'b0});
    assign o_in_stall = q_head > (OQ_CW+2)'(OQ_DEPTH - 2);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign flushing = LH'(r_row) >= h_eff;
    assign proc     = in_acc && (((i_mode == MODE_PIXEL) && !flushing)
                              || ((i_mode == MODE_FLUSH) && flushing));
    assign last_col = (LW+1)'(r_col) + (LW+1)'(1) >= (LW+1)'(w_eff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (proc) begin
            if (last_col) begin
                n_col = '0;
                n_row = flushing ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_proc   <= proc;
        r_s1_tload  <= (i_mode == MODE_TABLE);
        r_s1_tidx   <= i_table_word_index;
        r_s1_tword  <= i_table_word;
        r_s1_c      <= r_col;
        r_s1_bot    <= (i_mode == MODE_PIXEL) ? i_pixel_in : r_background;
        r_s1_top_bg <= (r_row < RW'(2));
        r_s1_mid_bg <= (r_row == '0);
        r_s1_first  <= (r_col == '0);
        r_s1_emit1  <= (r_col != '0) && (r_row != '0);
        r_s1_emit2  <= last_col && (r_row != '0);
        r_s1_last   <= flushing;
        r_s1_clear  <= last_col && flushing;
        r_s1_row    <= 8'(r_row - RW'(1));
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_s1_valid <= in_acc;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    // ---------------- window stage ----------------
    blf_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (s1_work),
        .i_wr_addr (r_s1_c),
        .i_wr_data ({s1_mid, r_s1_bot}),
        .o_rd_data (lb_rdata)
    );

    assign s1_work = r_s1_valid && r_s1_proc;
    assign bgcol   = {3{r_background}};
    assign s1_top  = r_s1_top_bg ? r_background : lb_rdata[1];
    assign s1_mid  = r_s1_mid_bg ? r_background : lb_rdata[0];
    assign s1_new  = {s1_top, s1_mid, r_s1_bot};
    assign n_win   = {(r_s1_first ? bgcol : r_win[2:0]), s1_new};
    assign idx1    = lut_index(r_win[5:3], r_win[2:0], s1_new);
    assign idx2    = lut_index(n_win[5:3], n_win[2:0], bgcol);

    blf_table u_table (
        .i_clk       (i_clk),
        .i_wr_en     (r_s1_valid && r_s1_tload),
        .i_wr_addr   (r_s1_tidx),
        .i_wr_data   (r_s1_tword),
        .i_rd_addr_a (idx1[8:6]),
        .i_rd_addr_b (idx2[8:6]),
        .o_rd_data_a (tq_a),
        .o_rd_data_b (tq_b)
    );

    always_ff @(posedge i_clk) begin
        r_s2_emit1 <= r_s1_emit1;
        r_s2_emit2 <= r_s1_emit2;
        r_s2_last  <= r_s1_last;
        r_s2_clear <= r_s1_clear;
        r_s2_off1  <= idx1[5:0];
        r_s2_off2  <= idx2[5:0];
        r_s2_row   <= r_s1_row;
        r_s2_c     <= r_s1_c;
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s2_valid <= s1_work;
            if (s1_work) begin
                r_win <= n_win;
            end
        end
    end

    // ---------------- bit-select stage ----------------
    assign bit_a  = tq_a[r_s2_off1];
    assign bit_b  = tq_b[r_s2_off2];
    assign push_a = r_s2_valid && r_s2_emit1;
    assign push_b = r_s2_valid && r_s2_emit2;

    always_comb begin
        lit_a = r_lit;
        if (push_a && bit_a && (r_lit != LIT_MAX)) begin
            lit_a = r_lit + LIT_W'(1);
        end
        lit_b = lit_a;
        if (push_b && bit_b && (lit_a != LIT_MAX)) begin
            lit_b = lit_a + LIT_W'(1);
        end
    end

    always_comb begin
        res_a.pixel_out  = bit_a;
        res_a.out_row    = r_s2_row;
        res_a.out_col    = 8'(r_s2_c - CW'(1));
        res_a.frame_last = 1'b0;
        res_a.lit_count  = lit_a;
        res_b.pixel_out  = bit_b;
        res_b.out_row    = r_s2_row;
        res_b.out_col    = 8'(r_s2_c);
        res_b.frame_last = r_s2_last;
        res_b.lit_count  = lit_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit <= '0;
        end else if (r_s2_valid) begin
            // restart the count once the flush row has gone out
            r_lit <= r_s2_clear ? '0 : lit_b;
        end
    end

    blf_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_res_a  (res_a),
        .i_push_b (push_b),
        .i_res_b  (res_b),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_res    (q_res),
        .o_count  (q_count)
    );

    assign o_pixel_out  = q_res.pixel_out;
    assign o_out_row    = q_res.out_row;
    assign o_out_col    = q_res.out_col;
    assign o_frame_last = q_res.frame_last;
    assign o_lit_count  = q_res.lit_count;

    `BLF_ASSERT_IMPL(a_row_range, i_clk, i_rst_n, 1'b1, r_row <= RW'(MAX_HEIGHT))
    `BLF_ASSERT_IMPL(a_clear_on_last, i_clk, i_rst_n, r_s1_valid && r_s1_proc && r_s1_clear, r_s1_emit2 && r_s1_last)
    `BLF_ASSERT_NEXT(a_lit_restart, i_clk, i_rst_n, r_s2_valid && r_s2_clear, r_lit == '0)

endmodule

`default_nettype wire

// File: test/filter_checker.sv
// Checker for the binary 3x3 lookup-table filter: predicts each filtered pixel from the
// accepted items and register writes, then compares the results in order, field by field.
// Depends on blf_pkg for item modes, register indexes and the result layout.
module filter_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic        i_pixel_in,
    input  wire logic [2:0]  i_table_word_index,
    input  wire logic [63:0] i_table_word,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        i_pixel_out,
    input  wire logic [7:0]  i_out_row,
    input  wire logic [7:0]  i_out_col,
    input  wire logic        i_frame_last,
    input  wire logic [16:0] i_lit_count,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    import blf_pkg::*;

    localparam int LINE_MAX = 256;

    logic [63:0] lut_words [8];
    bit          upper_line [LINE_MAX];
    bit          lower_line [LINE_MAX];
    logic [5:0]  window;        // [5:3] left column, [2:0] centre column, top bit first
    int unsigned row_pos;
    int unsigned col_pos;
    logic [16:0] lit_total;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic        bg_reg;
    t_result     filtered_q [$];
    t_result     got;
    t_result     want;

    function automatic int unsigned fit_size(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (32'(v) > LINE_MAX) return LINE_MAX;
        return 32'(v);
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("pix=%0b row=%0d col=%0d last=%0b lit=%0d",
                         r.pixel_out, r.out_row, r.out_col, r.frame_last, r.lit_count);
    endfunction

    task automatic note_failure(input string msg);
        if (o_fail_count < 10) $display("%s", msg);
        o_fail_count++;
    endtask

    task automatic lookup_pixel(input logic [2:0] l, input logic [2:0] m, input logic [2:0] r,
                                input int unsigned row, input int unsigned col, input bit last);
        logic [8:0] idx;
        t_result    res;
        idx = '0;
        // gather row by row, top row first, left to right
        for (int s = 2; s >= 0; s--) idx = {idx[5:0], l[s], m[s], r[s]};
        res.pixel_out = lut_words[idx[8:6]][idx[5:0]];
        if (res.pixel_out && lit_total != LIT_MAX) lit_total = lit_total + 17'd1;
        res.out_row    = row[7:0];
        res.out_col    = col[7:0];
        res.frame_last = last;
        res.lit_count  = lit_total;
        filtered_q.push_back(res);
    endtask

    task automatic filter_item(input logic [1:0] mode, input logic pix,
                               input logic [2:0] widx, input logic [63:0] word);
        int unsigned w, h, c;
        logic [2:0]  bgcol, col_new, left, centre;
        logic        top, mid, bot;
        bit          flushing, last_col;
        w        = fit_size(width_reg);
        h        = fit_size(height_reg);
        bgcol    = {3{bg_reg}};
        flushing = (row_pos >= h);
        if (mode == MODE_TABLE) begin
            lut_words[widx] = word;
            return;
        end
        if (mode != MODE_PIXEL && mode != MODE_FLUSH) return;
        if (mode == MODE_PIXEL && flushing) return;
        if (mode == MODE_FLUSH && !flushing) return;

        c       = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        top     = (row_pos >= 2) ? upper_line[c] : bg_reg;
        mid     = (row_pos >= 1) ? lower_line[c] : bg_reg;
        bot     = (mode == MODE_PIXEL) ? pix : bg_reg;
        col_new = {top, mid, bot};
        upper_line[c] = mid;
        lower_line[c] = bot;
        last_col = (c + 1 >= w);

        if (c == 0) begin
            left   = bgcol;
            centre = col_new;
        end else begin
            left   = window[5:3];
            centre = window[2:0];
            if (row_pos >= 1) lookup_pixel(left, centre, col_new, row_pos - 1, c - 1, 1'b0);
            left   = centre;
            centre = col_new;
        end
        window = {left, centre};

        if (last_col) begin
            // rightmost column sees the background on its right
            if (row_pos >= 1) lookup_pixel(left, centre, bgcol, row_pos - 1, c, flushing);
            col_pos = 0;
            if (flushing) begin
                row_pos   = 0;
                lit_total = '0;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window     = '0;
            row_pos    = 0;
            col_pos    = 0;
            lit_total  = '0;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            bg_reg     = 1'b0;
            filtered_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_pixel_out, i_out_row, i_out_col, i_frame_last, i_lit_count};
                if (filtered_q.size() == 0) begin
                    note_failure({"filtered pixel with nothing expected: ", show(got)});
                end else begin
                    want = filtered_q.pop_front();
                    o_checked++;
                    if (got.pixel_out !== want.pixel_out || got.out_row !== want.out_row ||
                        got.out_col !== want.out_col || got.frame_last !== want.frame_last ||
                        got.lit_count !== want.lit_count)
                        note_failure($sformatf("filtered pixel mismatch: expected %s, got %s",
                                               show(want), show(got)));
                end
            end
            if (i_in_valid && !i_in_stall)
                filter_item(i_mode, i_pixel_in, i_table_word_index, i_table_word);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH:   width_reg  = i_cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    CFG_BACKGROUND:   bg_reg     = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = filtered_q.size();
    end

endmodule

// File: test/tb.sv
// Top of the filter testbench: clock, reset, stimulus, idling and the verdict.
// Drives binary_3x3_lut_image_filter_core and checks it through filter_checker.
// Depends on blf_pkg, the RTL and test/filter_checker.sv.
module tb;
    import blf_pkg::*;

    localparam int         ITEM_TARGET   = 1950;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         SIZE_MAX      = 256;
    localparam int         NOISE_PCT     = 6;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic        i_pixel_in;
    logic [2:0]  i_table_word_index;
    logic [63:0] i_table_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_pixel_out;
    logic [7:0]  o_out_row;
    logic [7:0]  o_out_col;
    logic        o_frame_last;
    logic [16:0] o_lit_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    int fail_count;
    int pending_count;
    int checked_count;
    int send_idle_pct = 33;
    int recv_idle_pct = 58;
    int items_sent;
    int frames_done;
    int resizes;
    int w_eff;
    int h_eff;
    int cycle_count;

    binary_3x3_lut_image_filter_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_pixel_in         (i_pixel_in),
        .i_table_word_index (i_table_word_index),
        .i_table_word       (i_table_word),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_pixel_out        (o_pixel_out),
        .o_out_row          (o_out_row),
        .o_out_col          (o_out_col),
        .o_frame_last       (o_frame_last),
        .o_lit_count        (o_lit_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    filter_checker u_filter_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_pixel_in         (i_pixel_in),
        .i_table_word_index (i_table_word_index),
        .i_table_word       (i_table_word),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_pixel_out        (o_pixel_out),
        .i_out_row          (o_out_row),
        .i_out_col          (o_out_col),
        .i_frame_last       (o_frame_last),
        .i_lit_count        (o_lit_count),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending_count),
        .o_checked          (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("tb: errors");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic int fit_size(input int v);
        if (v == 0) return 1;
        return (v > SIZE_MAX) ? SIZE_MAX : v;
    endfunction

    // call at a falling edge; returns at the falling edge after the transaction
    task automatic push_item(input logic [1:0] mode, input logic pix,
                             input logic [2:0] widx, input logic [63:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid         = 1'b1;
        i_mode             = mode;
        i_pixel_in         = pix;
        i_table_word_index = widx;
        i_table_word       = word;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_pixel(input logic pix);
        push_item(MODE_PIXEL, pix, 3'($urandom_range(7)), {$urandom, $urandom});
        items_sent++;
    endtask

    task automatic send_flush();
        push_item(MODE_FLUSH, 1'($urandom_range(1)), 3'($urandom_range(7)),
                  {$urandom, $urandom});
        items_sent++;
    endtask

    task automatic send_lut_word(input logic [2:0] widx, input logic [63:0] word);
        push_item(MODE_TABLE, 1'($urandom_range(1)), widx, word);
        items_sent++;
    endtask

    // items the block drops, plus table reloads that must not disturb the stream
    task automatic send_noise(input bit in_flush);
        case ($urandom_range(2))
            0: push_item(MODE_UNUSED, 1'($urandom_range(1)), 3'($urandom_range(7)),
                         {$urandom, $urandom});
            1: send_lut_word(3'($urandom_range(7)), {$urandom, $urandom});
            default: push_item(in_flush ? MODE_PIXEL : MODE_FLUSH, 1'($urandom_range(1)),
                               3'($urandom_range(7)), {$urandom, $urandom});
        endcase
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait for every outstanding result, then for anything still in the pipe
    task automatic settle();
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input int wv, input int hv, input logic bgv);
        settle();
        write_reg(CFG_LINE_WIDTH, wv[8:0]);
        write_reg(CFG_FRAME_HEIGHT, hv[8:0]);
        write_reg(CFG_BACKGROUND, {8'd0, bgv});
        w_eff = fit_size(wv);
        h_eff = fit_size(hv);
    endtask

    // one frame plus its flush row; cut may shrink a size register somewhere mid-frame
    task automatic run_frame(input int density, input bit cut);
        int r, c, n, cut_at, v;
        r      = 0;
        c      = 0;
        n      = 0;
        cut_at = -1;
        if (cut) cut_at = $urandom_range(w_eff * h_eff - 1);
        while (r < h_eff) begin
            if ($urandom_range(99) < NOISE_PCT) send_noise(1'b0);
            send_pixel($urandom_range(99) < density);
            if (c + 1 >= w_eff) begin
                c = 0;
                r++;
            end else begin
                c++;
            end
            if (n == cut_at) begin
                settle();
                if ($urandom_range(1)) begin
                    v = $urandom_range(w_eff);
                    write_reg(CFG_LINE_WIDTH, v[8:0]);
                    w_eff = fit_size(v);
                end else begin
                    v = $urandom_range(h_eff);
                    write_reg(CFG_FRAME_HEIGHT, v[8:0]);
                    h_eff = fit_size(v);
                end
                resizes++;
            end
            n++;
        end
        // a height cut mid-row leaves a partial flush row from column c
        while (c < w_eff) begin
            if ($urandom_range(99) < NOISE_PCT) send_noise(1'b1);
            send_flush();
            c++;
        end
        frames_done++;
    endtask

    initial begin
        int sel, wv, hv, phase, last_phase, density;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_mode             = MODE_PIXEL;
        i_pixel_in         = 1'b0;
        i_table_word_index = '0;
        i_table_word       = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = CFG_LINE_WIDTH;
        i_cfg_data         = '0;
        last_phase         = -1;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // load the whole table first so no lookup hits an unwritten word
        configure(3, 2, 1'b0);
        send_lut_word(3'd0, '0);
        send_lut_word(3'd7, '1);
        for (int k = 1; k < 7; k++) send_lut_word(3'(k), {$urandom, $urandom});
        send_pixel(1'b1);
        push_item(MODE_UNUSED, 1'b1, 3'd5, '1);
        send_pixel(1'b0);
        push_item(MODE_FLUSH, 1'b0, 3'd0, '0);   // frame incomplete: dropped
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_lut_word(3'd3, {$urandom, $urandom});
        send_pixel(1'b1);
        send_pixel(1'b1);
        push_item(MODE_PIXEL, 1'b1, 3'd0, '0);   // rows complete: dropped
        repeat (3) send_flush();
        // zero sizes act as one, lit background
        configure(0, 0, 1'b1);
        send_pixel(1'b1);
        send_flush();
        frames_done += 2;

        while (items_sent < ITEM_TARGET) begin
            phase = items_sent * 3 / ITEM_TARGET;
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 33 : 0;
            if (phase != last_phase && phase < 2) begin
                // one frame per idling pattern: one size above the limit, the other acting as one
                if (phase == 0) configure(511, 1, 1'($urandom_range(1)));
                else configure(0, 511, 1'($urandom_range(1)));
                run_frame($urandom_range(100), 1'b0);
            end else begin
                sel = $urandom_range(9);
                if (sel < 6) begin
                    wv = $urandom_range(1, 8);
                    hv = $urandom_range(1, 6);
                end else if (sel < 8) begin
                    wv = $urandom_range(9, 48);
                    hv = $urandom_range(1, 3);
                end else begin
                    wv = $urandom_range(1, 3);
                    hv = $urandom_range(9, 48);
                end
                if ($urandom_range(19) == 0) wv = 0;
                if ($urandom_range(19) == 0) hv = 0;
                if ($urandom_range(3) == 0) density = $urandom_range(1) ? 100 : 0;
                else density = $urandom_range(100);
                configure(wv, hv, 1'($urandom_range(1)));
                run_frame(density, $urandom_range(5) == 0);
            end
            last_phase = phase;
        end

        settle();
        $display("summary: %0d items in %0d frames, %0d filtered pixels compared",
                 items_sent, frames_done, checked_count);
        $display("summary: sizes 1 to 256 both ways, both backgrounds, %0d mid-frame resizes",
                 resizes);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, pending_count);
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/blf_pkg.sv
rtl/blf_linebuf.sv
rtl/blf_table.sv
rtl/blf_outq.sv
rtl/binary_3x3_lut_image_filter_core.sv
test/filter_checker.sv
test/tb.sv
